/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers shared by the water quality monitor RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of aclk outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        ((ante) |-> (cons))) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        ((ante) |=> (cons))) else $error(msg);

`endif

/* design/wqam_pkg.sv */
// ----------------------------------------------------------------------------
// Water quality monitor package
// Shared widths, codes and interface structures of the alert monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package wqam_pkg;

    localparam int SUM_W      = 25;
    localparam int CNT_W      = 9;
    localparam int LIMIT_W    = 15;
    localparam int WIN_W      = 9;
    localparam int DAY_W      = 16;
    localparam int DAYPOS_W   = 9;
    localparam int CHG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;
    localparam int PROD_W     = LIMIT_W + CNT_W;
    localparam int S_USER_W   = 3;
    localparam int M_USER_W   = 4;
    localparam int M_FIELDS_W = DAY_W + DAYPOS_W + SUM_W + CNT_W + CHG_W + CHG_W;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [CNT_W-1:0]        CNT_MAX = {CNT_W{1'b1}};
    localparam logic [DAY_W-1:0]        DAY_MAX = {DAY_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_END   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DO_SEVERE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DO_LOW       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SAL_HOUR     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SAL_DAY      = 3'd5;

    typedef enum logic [1:0] {
        OX_NONE   = 2'd0,
        OX_LOW    = 2'd1,
        OX_SEVERE = 2'd2
    } ox_alert_t;

    typedef struct packed {
        logic en;
        logic clear;
        logic add;
        logic close;
    } win_ctrl_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [CNT_W-1:0]        cnt;
    } win_close_t;

endpackage

`default_nettype wire

/* design/wqam_cell.sv */
// ----------------------------------------------------------------------------
// Salinity history cell
// One stage of the one-day salinity delay line: a usable flag and a value.
// ----------------------------------------------------------------------------
`default_nettype none

module wqam_cell #(
    parameter int VALUE_BITS = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         shift_en,
    input  wire logic                         usable_in,
    input  wire logic signed [VALUE_BITS-1:0] value_in,
    output logic                              usable_out,
    output logic signed [VALUE_BITS-1:0]      value_out
);

    logic                         usable_reg;
    logic signed [VALUE_BITS-1:0] value_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            usable_reg <= 1'b0;
        end else if (shift_en) begin
            usable_reg <= usable_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            value_reg <= value_in;
        end
    end

    assign usable_out = usable_reg;
    assign value_out  = value_reg;

endmodule

`default_nettype wire

/* design/wqam_delay_line.sv */
// ----------------------------------------------------------------------------
// Salinity delay line
// A row of history cells one day long, tapped one hour and one day back.
// ----------------------------------------------------------------------------
`default_nettype none

module wqam_delay_line #(
    parameter int SAMPLES_PER_DAY = 288,
    parameter int HOUR_LAG        = 12,
    parameter int VALUE_BITS      = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         shift_en,
    input  wire logic                         usable_in,
    input  wire logic signed [VALUE_BITS-1:0] value_in,
    output logic                              hour_usable,
    output logic signed [VALUE_BITS-1:0]      hour_value,
    output logic                              day_usable,
    output logic signed [VALUE_BITS-1:0]      day_value
);

    // A lag of a whole day lands on the day tap.
    localparam int LAG_MOD  = HOUR_LAG % SAMPLES_PER_DAY;
    localparam int HOUR_TAP = (LAG_MOD == 0) ? SAMPLES_PER_DAY : LAG_MOD;

    logic                         use_chain [0:SAMPLES_PER_DAY];
    logic signed [VALUE_BITS-1:0] val_chain [0:SAMPLES_PER_DAY];

    assign use_chain[0] = usable_in;
    assign val_chain[0] = value_in;

    for (genvar k = 0; k < SAMPLES_PER_DAY; k++) begin : g_cell
        wqam_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .shift_en   (shift_en),
            .usable_in  (use_chain[k]),
            .value_in   (val_chain[k]),
            .usable_out (use_chain[k+1]),
            .value_out  (val_chain[k+1])
        );
    end

    assign hour_usable = use_chain[HOUR_TAP];
    assign hour_value  = val_chain[HOUR_TAP];
    assign day_usable  = use_chain[SAMPLES_PER_DAY];
    assign day_value   = val_chain[SAMPLES_PER_DAY];

endmodule

`default_nettype wire

/* design/wqam_window.sv */
// ----------------------------------------------------------------------------
// Oxygen window accumulator
// Saturating sum and count of usable oxygen samples over the daily window.
// ----------------------------------------------------------------------------
`default_nettype none

module wqam_window #(
    parameter int VALUE_BITS = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire wqam_pkg::win_ctrl_t          ctrl,
    input  wire logic signed [VALUE_BITS-1:0] oxygen,
    output wqam_pkg::win_close_t              result
);

    localparam int EXT_W = (VALUE_BITS > wqam_pkg::SUM_W ? VALUE_BITS : wqam_pkg::SUM_W) + 1;

    logic signed [wqam_pkg::SUM_W-1:0] sum_reg, sum_next, base_sum, sat_sum, add_sum;
    logic [wqam_pkg::CNT_W-1:0]        cnt_reg, cnt_next, base_cnt, add_cnt;
    logic signed [EXT_W-1:0]           wide_sum;

    always_comb begin
        base_sum = ctrl.clear ? '0 : sum_reg;
        base_cnt = ctrl.clear ? '0 : cnt_reg;
        wide_sum = EXT_W'(base_sum) + EXT_W'(oxygen);
        if (wide_sum > EXT_W'(wqam_pkg::SUM_MAX)) begin
            sat_sum = wqam_pkg::SUM_MAX;
        end else if (wide_sum < EXT_W'(wqam_pkg::SUM_MIN)) begin
            sat_sum = wqam_pkg::SUM_MIN;
        end else begin
            sat_sum = wide_sum[wqam_pkg::SUM_W-1:0];
        end
        add_sum = ctrl.add ? sat_sum : base_sum;
        if (ctrl.add && base_cnt != wqam_pkg::CNT_MAX) begin
            add_cnt = base_cnt + 1'b1;
        end else begin
            add_cnt = base_cnt;
        end
        sum_next = ctrl.close ? '0 : add_sum;
        cnt_next = ctrl.close ? '0 : add_cnt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end else if (ctrl.en) begin
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
        end
    end

    assign result.sum = add_sum;
    assign result.cnt = add_cnt;

endmodule

`default_nettype wire

/* design/water_quality_alert_monitor.sv */
// ----------------------------------------------------------------------------
// Water quality alert monitor
// Windowed oxygen average and lagged salinity difference alarm.
// ----------------------------------------------------------------------------
// Channel  Direction  Carries
// s_       in         one sensor record per transfer, tlast marks the final one
// m_       out        one alert record per record that raises any alert
// cfg_     in         register writes, one register per cycle
//
// One record is taken in every cycle while s_tready is high; its alert passes
// through two compute stages, then the output register.
// The window sum update is the loop that sets this rate.
// The output register is backed by one skid entry; s_tready falls only while
// that entry is occupied. Reset clears the delay line flags at once.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module water_quality_alert_monitor #(
    parameter int SAMPLES_PER_DAY = 288,
    parameter int HOUR_LAG        = 12,
    parameter int VALUE_BITS      = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [wqam_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [wqam_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // oxygen, salinity
    input  wire logic [((2*VALUE_BITS+7)/8)*8-1:0]   s_tdata,
    // record_valid, oxygen_ok, salinity_ok
    input  wire logic [wqam_pkg::S_USER_W-1:0]       s_tuser,
    input  wire logic                                s_tlast,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // day_number, day_position, window_sum, window_count, hour_change, day_drop
    output logic [wqam_pkg::M_DATA_W-1:0]            m_tdata,
    // oxygen_alert, hour_alert, day_alert
    output logic [wqam_pkg::M_USER_W-1:0]            m_tuser
);

    localparam int POS_W = (SAMPLES_PER_DAY > 2) ? $clog2(SAMPLES_PER_DAY) : 1;
    localparam int CMP_W = (POS_W > wqam_pkg::WIN_W ? POS_W : wqam_pkg::WIN_W) + 1;
    localparam int D_W   = (VALUE_BITS + 1 > wqam_pkg::CHG_W + 1) ? VALUE_BITS + 1
                                                                  : wqam_pkg::CHG_W + 1;
    localparam int PAD_W = wqam_pkg::M_DATA_W - wqam_pkg::M_FIELDS_W;

    localparam logic [CMP_W-1:0]      SPD_C   = CMP_W'(SAMPLES_PER_DAY);
    localparam logic [POS_W-1:0]      POS_END = POS_W'(SAMPLES_PER_DAY - 1);
    localparam logic signed [D_W-1:0] CHG_MAX = D_W'(65535);

    logic [wqam_pkg::WIN_W-1:0]   window_start_reg, window_end_reg;
    logic [wqam_pkg::LIMIT_W-1:0] do_severe_reg, do_low_reg, sal_hour_reg, sal_day_reg;

    logic [POS_W-1:0]           pos_reg;
    logic [wqam_pkg::DAY_W-1:0] day_reg;

    logic                         adv, s_accept;
    logic                         rec_valid, ox_ok, sal_ok, sal_use;
    logic signed [VALUE_BITS-1:0] ox_in, sal_in;
    logic [CMP_W-1:0]             pos_ext, wend_ext, wend;
    logic                         in_win, closes;

    wqam_pkg::win_ctrl_t  win_ctrl;
    wqam_pkg::win_close_t win_res;

    logic                         hour_usable, day_usable;
    logic signed [VALUE_BITS-1:0] hour_value, day_value;
    logic signed [D_W-1:0]        hour_diff, day_diff;

    logic                              s1_valid_reg;
    logic [wqam_pkg::DAY_W-1:0]        s1_day_reg;
    logic [wqam_pkg::DAYPOS_W-1:0]     s1_pos_reg;
    logic signed [wqam_pkg::SUM_W-1:0] s1_sum_reg;
    logic [wqam_pkg::CNT_W-1:0]        s1_cnt_reg;
    logic                              s1_hour_ok_reg, s1_day_ok_reg;
    logic signed [D_W-1:0]             s1_hour_diff_reg, s1_day_diff_reg;

    logic signed [D_W-1:0]       hour_mag, hour_lim, day_lim;
    logic [wqam_pkg::CHG_W-1:0]  hour_change, day_drop;
    logic                        hour_alert, day_alert;

    logic                              s2_valid_reg;
    logic [wqam_pkg::DAY_W-1:0]        s2_day_reg;
    logic [wqam_pkg::DAYPOS_W-1:0]     s2_pos_reg;
    logic signed [wqam_pkg::SUM_W-1:0] s2_sum_reg;
    logic [wqam_pkg::CNT_W-1:0]        s2_cnt_reg;
    logic [wqam_pkg::PROD_W-1:0]       s2_prod_sev_reg, s2_prod_low_reg;
    logic                              s2_hour_alert_reg, s2_day_alert_reg;
    logic [wqam_pkg::CHG_W-1:0]        s2_hour_change_reg, s2_day_drop_reg;

    wqam_pkg::ox_alert_t                 ox_alert;
    logic signed [wqam_pkg::SUM_W:0]     sum_ext;
    logic                                emit, push, pop;
    logic [wqam_pkg::M_DATA_W-1:0]       push_data;
    logic [wqam_pkg::M_USER_W-1:0]       push_user;

    logic                          m_tvalid_reg, skid_valid_reg;
    logic [wqam_pkg::M_DATA_W-1:0] m_data_reg, skid_data_reg;
    logic [wqam_pkg::M_USER_W-1:0] m_user_reg, skid_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_start_reg <= 9'd180;
            window_end_reg   <= 9'd240;
            do_severe_reg    <= 15'd768;
            do_low_reg       <= 15'd1024;
            sal_hour_reg     <= 15'd512;
            sal_day_reg      <= 15'd1280;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                wqam_pkg::CFG_WINDOW_START: begin
                    window_start_reg <= cfg_wdata[wqam_pkg::WIN_W-1:0];
                end
                wqam_pkg::CFG_WINDOW_END: begin
                    window_end_reg <= cfg_wdata[wqam_pkg::WIN_W-1:0];
                end
                wqam_pkg::CFG_DO_SEVERE: begin
                    do_severe_reg <= cfg_wdata;
                end
                wqam_pkg::CFG_DO_LOW: begin
                    do_low_reg <= cfg_wdata;
                end
                wqam_pkg::CFG_SAL_HOUR: begin
                    sal_hour_reg <= cfg_wdata;
                end
                wqam_pkg::CFG_SAL_DAY: begin
                    sal_day_reg <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    assign adv      = !skid_valid_reg;
    assign s_tready = adv;
    assign s_accept = s_tvalid && adv;

    always_comb begin
        rec_valid = s_tuser[0];
        ox_ok     = s_tuser[1];
        sal_ok    = s_tuser[2];
        sal_use   = rec_valid && sal_ok;
        ox_in     = s_tdata[VALUE_BITS-1:0];
        sal_in    = s_tdata[2*VALUE_BITS-1:VALUE_BITS];
        pos_ext   = CMP_W'(pos_reg);
        wend_ext  = CMP_W'(window_end_reg);
        wend      = (wend_ext > SPD_C) ? SPD_C : wend_ext;
        in_win    = (pos_ext >= CMP_W'(window_start_reg)) && (pos_ext < wend);
        closes    = s_tlast || ((wend != '0) && ((pos_ext + CMP_W'(1)) == wend));
        win_ctrl.en    = s_accept;
        win_ctrl.clear = (pos_reg == '0);
        win_ctrl.add   = rec_valid && ox_ok && in_win;
        win_ctrl.close = closes;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            day_reg <= '0;
        end else if (s_accept) begin
            if (pos_reg == POS_END) begin
                pos_reg <= '0;
                if (day_reg != wqam_pkg::DAY_MAX) begin
                    day_reg <= day_reg + 1'b1;
                end
            end else begin
                pos_reg <= pos_reg + 1'b1;
            end
        end
    end

    wqam_window #(
        .VALUE_BITS (VALUE_BITS)
    ) u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (win_ctrl),
        .oxygen  (ox_in),
        .result  (win_res)
    );

    wqam_delay_line #(
        .SAMPLES_PER_DAY (SAMPLES_PER_DAY),
        .HOUR_LAG        (HOUR_LAG),
        .VALUE_BITS      (VALUE_BITS)
    ) u_delay_line (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .shift_en    (s_accept),
        .usable_in   (sal_use),
        .value_in    (sal_in),
        .hour_usable (hour_usable),
        .hour_value  (hour_value),
        .day_usable  (day_usable),
        .day_value   (day_value)
    );

    always_comb begin
        hour_diff = D_W'(sal_in) - D_W'(hour_value);
        day_diff  = D_W'(day_value) - D_W'(sal_in);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_day_reg       <= day_reg;
            s1_pos_reg       <= wqam_pkg::DAYPOS_W'(pos_reg);
            s1_sum_reg       <= closes ? win_res.sum : '0;
            s1_cnt_reg       <= closes ? win_res.cnt : '0;
            s1_hour_ok_reg   <= sal_use && hour_usable;
            s1_day_ok_reg    <= sal_use && day_usable;
            s1_hour_diff_reg <= hour_diff;
            s1_day_diff_reg  <= day_diff;
        end
    end

    always_comb begin
        hour_mag = (s1_hour_diff_reg < 0) ? -s1_hour_diff_reg : s1_hour_diff_reg;
        hour_lim = D_W'(sal_hour_reg);
        day_lim  = D_W'(sal_day_reg);
        if (!s1_hour_ok_reg) begin
            hour_change = '0;
        end else if (hour_mag > CHG_MAX) begin
            hour_change = '1;
        end else begin
            hour_change = wqam_pkg::CHG_W'(hour_mag);
        end
        hour_alert = s1_hour_ok_reg && (hour_mag > hour_lim);
        if (!s1_day_ok_reg || s1_day_diff_reg < 0) begin
            day_drop = '0;
        end else if (s1_day_diff_reg > CHG_MAX) begin
            day_drop = '1;
        end else begin
            day_drop = wqam_pkg::CHG_W'(s1_day_diff_reg);
        end
        day_alert = s1_day_ok_reg && (s1_day_diff_reg > day_lim);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_day_reg         <= s1_day_reg;
            s2_pos_reg         <= s1_pos_reg;
            s2_sum_reg         <= s1_sum_reg;
            s2_cnt_reg         <= s1_cnt_reg;
            s2_prod_sev_reg    <= wqam_pkg::PROD_W'(do_severe_reg)
                                  * wqam_pkg::PROD_W'(s1_cnt_reg);
            s2_prod_low_reg    <= wqam_pkg::PROD_W'(do_low_reg)
                                  * wqam_pkg::PROD_W'(s1_cnt_reg);
            s2_hour_alert_reg  <= hour_alert;
            s2_hour_change_reg <= hour_change;
            s2_day_alert_reg   <= day_alert;
            s2_day_drop_reg    <= day_drop;
        end
    end

    always_comb begin
        sum_ext = (wqam_pkg::SUM_W + 1)'(s2_sum_reg);
        if (s2_cnt_reg == '0) begin
            ox_alert = wqam_pkg::OX_NONE;
        end else if (sum_ext < $signed({2'b00, s2_prod_sev_reg})) begin
            ox_alert = wqam_pkg::OX_SEVERE;
        end else if (sum_ext < $signed({2'b00, s2_prod_low_reg})) begin
            ox_alert = wqam_pkg::OX_LOW;
        end else begin
            ox_alert = wqam_pkg::OX_NONE;
        end
        emit = s2_valid_reg && ((ox_alert != wqam_pkg::OX_NONE)
                                || s2_hour_alert_reg || s2_day_alert_reg);
        push = adv && emit;
        pop  = m_tvalid_reg && m_tready;
        push_data = {{PAD_W{1'b0}}, s2_day_drop_reg, s2_hour_change_reg, s2_cnt_reg,
                     s2_sum_reg, s2_pos_reg, s2_day_reg};
        push_user = {s2_day_alert_reg, s2_hour_alert_reg, ox_alert};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg   <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_tvalid_reg || pop) begin
            if (skid_valid_reg) begin
                m_tvalid_reg   <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_tvalid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_tvalid_reg || pop) begin
            if (skid_valid_reg) begin
                m_data_reg <= skid_data_reg;
                m_user_reg <= skid_user_reg;
            end else begin
                m_data_reg <= push_data;
                m_user_reg <= push_user;
            end
        end else if (push) begin
            skid_data_reg <= push_data;
            skid_user_reg <= push_user;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    `ASSERT_IMPLIES(a_skid_needs_main, skid_valid_reg, m_tvalid_reg,
        "Skid entry holds a transfer while the output register is empty.")
    `ASSERT_IMPLIES(a_result_has_alert, m_tvalid_reg, m_user_reg != '0,
        "Result transfer carries no alert.")
    `ASSERT_IMPLIES(a_oxygen_alert_count, m_tvalid_reg && m_user_reg[1:0] != wqam_pkg::OX_NONE,
        m_data_reg[58:50] != '0, "Oxygen alert raised on an empty window.")
    `ASSERT_NEXT(a_position_wraps, s_accept && pos_reg == POS_END, pos_reg == '0,
        "Position counter failed to wrap at the end of the day.")
    `ASSERT_NEXT(a_stall_holds_pipe, !adv && s2_valid_reg, s2_valid_reg,
        "Compute stage dropped an item while stalled.")

endmodule

`default_nettype wire
